FILE: hw/rtl/c3s_pkg.sv
package c3s_pkg;

  localparam int unsigned FRAME_WIDTH  = 64;
  localparam int unsigned FRAME_HEIGHT = 64;

  localparam int unsigned COL_W = $clog2(FRAME_WIDTH);
  localparam int unsigned ROW_W = $clog2(FRAME_HEIGHT);

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned WGT_W      = 16;
  localparam int unsigned PROD_W     = PIX_W + 1 + WGT_W;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned LB_W       = 2 * PIX_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned NUM_TAPS   = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_NEXT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LAST   = 2'd2;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [LB_W-1:0]  data;
  } lb_wr_t;

endpackage

FILE: hw/rtl/c3s_line_buf.sv
module c3s_line_buf (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [c3s_pkg::COL_W-1:0]  rd_addr_i,
  output logic [c3s_pkg::LB_W-1:0]   rd_data_o,
  input  c3s_pkg::lb_wr_t            wr_i
);

  logic [c3s_pkg::LB_W-1:0] mem_q [c3s_pkg::FRAME_WIDTH];
  logic [c3s_pkg::LB_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      // write-first on a same-column collision
      if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
        rd_data_q <= wr_i.data;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/c3s_mac_cell.sv
module c3s_mac_cell (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic        [c3s_pkg::PIX_W-1:0]   pixel_i,
  input  logic signed [c3s_pkg::WGT_W-1:0]   weight_i,
  input  logic signed [c3s_pkg::SUM_W-1:0]   acc_i,
  output logic signed [c3s_pkg::SUM_W-1:0]   acc_o
);

  logic signed [c3s_pkg::PROD_W-1:0] prod;
  logic signed [c3s_pkg::SUM_W-1:0]  acc_d;
  logic signed [c3s_pkg::SUM_W-1:0]  acc_q;

  assign prod  = $signed({1'b0, pixel_i}) * weight_i;
  assign acc_d = acc_i + c3s_pkg::SUM_W'(prod);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: hw/rtl/conv3x3_stream_top.sv
// an accepted word goes through the s1 registers, the tap cells and the output register
// throughput: one input word per cycle, set by the single line buffer port pair
// and the three-cell transposed tap chains; output stalls hold the whole pipe
// reset: position counters, weights and valid flags clear; line buffers are not
// cleared and hold no valid bits
module conv3x3_stream_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [c3s_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [c3s_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [c3s_pkg::PIX_W-1:0]            pixel_i,
  input  logic                                 frame_start_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [c3s_pkg::SUM_W-1:0]     conv_sum_o,
  output logic                                 frame_last_o
);

  localparam int unsigned COL_W = c3s_pkg::COL_W;
  localparam int unsigned ROW_W = c3s_pkg::ROW_W;
  localparam int unsigned PIX_W = c3s_pkg::PIX_W;
  localparam int unsigned WGT_W = c3s_pkg::WGT_W;
  localparam int unsigned SUM_W = c3s_pkg::SUM_W;
  localparam int unsigned LB_W  = c3s_pkg::LB_W;

  logic [c3s_pkg::CFG_DATA_W-1:0] w_first_q;
  logic [c3s_pkg::CFG_DATA_W-1:0] w_next_q;
  logic [WGT_W-1:0]               w_last_q;
  logic signed [WGT_W-1:0]        tap_w [c3s_pkg::NUM_TAPS];

  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic             at_last_col, at_last_row, produce, is_last;

  logic             adv, accept, cell_en;
  logic             s1_valid_q, s1_prod_q, s1_last_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s2_valid_q, s2_last_q;
  logic             out_valid_q, out_last_q;
  logic signed [SUM_W-1:0] out_sum_q, sum_d;

  logic [LB_W-1:0]        rd_data;
  c3s_pkg::lb_wr_t        lb_wr;
  logic [PIX_W-1:0]       col_px [3];
  logic signed [SUM_W-1:0] acc_in [3][3];
  logic signed [SUM_W-1:0] acc    [3][3];

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_first_q <= '0;
      w_next_q  <= '0;
      w_last_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        c3s_pkg::CFG_WEIGHTS_FIRST: w_first_q <= cfg_data_i;
        c3s_pkg::CFG_WEIGHTS_NEXT:  w_next_q  <= cfg_data_i;
        c3s_pkg::CFG_WEIGHT_LAST:   w_last_q  <= cfg_data_i[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tap_w[k]     = $signed(w_first_q[WGT_W*k +: WGT_W]);
      tap_w[k + 4] = $signed(w_next_q[WGT_W*k +: WGT_W]);
    end
    tap_w[8] = $signed(w_last_q);
  end

  // handshake
  assign adv        = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && adv;
  assign in_ready_o = adv;
  assign cell_en    = adv && s1_valid_q;

  // position
  assign col_cur     = frame_start_i ? '0 : col_q;
  assign row_cur     = frame_start_i ? '0 : row_q;
  assign at_last_col = (col_cur == COL_W'(c3s_pkg::FRAME_WIDTH - 1));
  assign at_last_row = (row_cur == ROW_W'(c3s_pkg::FRAME_HEIGHT - 1));
  assign produce     = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
  assign is_last     = at_last_col && at_last_row;

  always_comb begin
    if (at_last_col) begin
      col_d = '0;
      row_d = at_last_row ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_d = col_cur + COL_W'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (adv) begin
        s1_valid_q  <= in_valid_i;
        s2_valid_q  <= s1_valid_q && s1_prod_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_px_q    <= pixel_i;
      s1_col_q   <= col_cur;
      s1_prod_q  <= produce;
      s1_last_q  <= is_last;
      s2_last_q  <= s1_last_q;
      out_sum_q  <= sum_d;
      out_last_q <= s2_last_q;
    end
  end

  // line buffers, upper row in the high byte
  assign lb_wr.en   = cell_en;
  assign lb_wr.addr = s1_col_q;
  assign lb_wr.data = {rd_data[PIX_W-1:0], s1_px_q};

  c3s_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .rd_addr_i (col_cur),
    .rd_data_o (rd_data),
    .wr_i      (lb_wr)
  );

  assign col_px[0] = rd_data[LB_W-1:PIX_W];
  assign col_px[1] = rd_data[PIX_W-1:0];
  assign col_px[2] = s1_px_q;

  // one transposed three-tap chain per window row
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_tap
      if (j == 0) begin : g_head
        assign acc_in[r][j] = '0;
      end else begin : g_link
        assign acc_in[r][j] = acc[r][j-1];
      end
      c3s_mac_cell u_cell (
        .clk_i    (clk_i),
        .en_i     (cell_en),
        .pixel_i  (col_px[r]),
        .weight_i (tap_w[r*3 + j]),
        .acc_i    (acc_in[r][j]),
        .acc_o    (acc[r][j])
      );
    end
  end

  assign sum_d = acc[0][2] + acc[1][2] + acc[2][2];

  assign out_valid_o  = out_valid_q;
  assign conv_sum_o   = out_sum_q;
  assign frame_last_o = out_last_q;

endmodule
